### rtl/core/http_date_to_epoch_seconds_defines.svh
// ----------------------------------------------------------------------------
// HTTP date to epoch seconds - assertion macros
// Concurrent check wrappers, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef HTTP_DATE_TO_EPOCH_SECONDS_DEFINES_SVH
`define HTTP_DATE_TO_EPOCH_SECONDS_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HDTE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hdte assertion failed");
// next-cycle implication
`define HDTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hdte assertion failed");
`else
`define HDTE_ASSERT_NOW(label, clk, rst, ante, cons)
`define HDTE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/hdte_pkg.sv
// ----------------------------------------------------------------------------
// HTTP date to epoch seconds - package
// Shared types, field positions, calendar constants and lookup functions.
// ----------------------------------------------------------------------------
`default_nettype none

package hdte_pkg;

   // byte positions in the fixed date format
   localparam logic [4:0] DATE_LEN       = 5'd29;
   localparam logic [4:0] POS_DAY_TENS   = 5'd5;
   localparam logic [4:0] POS_DAY_UNITS  = 5'd6;
   localparam logic [4:0] POS_MON_FIRST  = 5'd8;
   localparam logic [4:0] POS_MON_SECOND = 5'd9;
   localparam logic [4:0] POS_MON_THIRD  = 5'd10;
   localparam logic [4:0] POS_YEAR_0     = 5'd12;
   localparam logic [4:0] POS_YEAR_1     = 5'd13;
   localparam logic [4:0] POS_YEAR_2     = 5'd14;
   localparam logic [4:0] POS_YEAR_3     = 5'd15;
   localparam logic [4:0] POS_HOUR_TENS  = 5'd17;
   localparam logic [4:0] POS_HOUR_UNITS = 5'd18;
   localparam logic [4:0] POS_MIN_TENS   = 5'd20;
   localparam logic [4:0] POS_MIN_UNITS  = 5'd21;
   localparam logic [4:0] POS_SEC_TENS   = 5'd23;
   localparam logic [4:0] POS_SEC_UNITS  = 5'd24;

   localparam logic [3:0] MONTH_NONE  = 4'd15;
   localparam logic [3:0] MONTH_COUNT = 4'd12;
   localparam logic [3:0] MONTH_FEB   = 4'd1;

   localparam logic [13:0] EPOCH_YEAR   = 14'd1970;
   localparam logic [22:0] LEAPS_TO_1969 = 23'd477;
   localparam logic [26:0] RECIP_100    = 27'd5243;   // 2^19 / 100, exact below 43699
   localparam logic [39:0] SECS_PER_DAY = 40'd86400;

   localparam logic [23:0] MONTH_NAMES [12] = '{
      24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072,
      24'h4D6179, 24'h4A756E, 24'h4A756C, 24'h417567,
      24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
   };

   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_QUOT,
      STEP_LEAPS,
      STEP_YEAR,
      STEP_DAYS,
      STEP_SECS,
      STEP_FAIL
   } dp_step_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUOT,
      ST_LEAPS,
      ST_YEAR,
      ST_DAYS,
      ST_SECS,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic        parse_en;
      logic        last_beat;
      dp_step_type step;
   } hdte_cmd_type;

   typedef struct packed {
      logic fields_ok;
   } hdte_sts_type;

   function automatic logic [3:0] month_lookup(input logic [23:0] name);
      logic [3:0] idx;
      idx = MONTH_NONE;
      for (int i = 11; i >= 0; i--) begin
         if (MONTH_NAMES[i] == name) begin
            idx = 4'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] days;
      case (month)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         4'd11:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

### rtl/core/hdte_ctrl.sv
// ----------------------------------------------------------------------------
// HTTP date to epoch seconds - controller
// Sequences byte intake, the conversion steps and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module hdte_ctrl
   import hdte_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tlast,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire hdte_sts_type sts,
   output hdte_cmd_type      cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      rsp_tvalid    = 1'b0;
      req_tready    = (state_ff == ST_IDLE) || ((state_ff == ST_OUT) && rsp_tready);
      accept        = req_tvalid && req_tready;
      cmd.parse_en  = accept;
      cmd.last_beat = accept && req_tlast;
      cmd.step      = STEP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tlast) begin
               state_in = ST_QUOT;
            end
         end
         ST_QUOT: begin
            // failed parse skips the arithmetic
            if (!sts.fields_ok) begin
               cmd.step = STEP_FAIL;
               state_in = ST_OUT;
            end else begin
               cmd.step = STEP_QUOT;
               state_in = ST_LEAPS;
            end
         end
         ST_LEAPS: begin
            cmd.step = STEP_LEAPS;
            state_in = ST_YEAR;
         end
         ST_YEAR: begin
            cmd.step = STEP_YEAR;
            state_in = ST_DAYS;
         end
         ST_DAYS: begin
            cmd.step = STEP_DAYS;
            state_in = ST_SECS;
         end
         ST_SECS: begin
            cmd.step = STEP_SECS;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = (accept && req_tlast) ? ST_QUOT : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/hdte_dp.sv
// ----------------------------------------------------------------------------
// HTTP date to epoch seconds - datapath
// Field capture per byte position and the staged day/second arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module hdte_dp
   import hdte_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [7:0]   char_byte,
   input  wire hdte_cmd_type cmd,
   output hdte_sts_type      sts,
   output logic              rsp_ok,
   output logic [38:0]       rsp_epoch_seconds
);

   // parse state
   logic [4:0]  pos_ff,    pos_in;
   logic [6:0]  day_ff,    day_in;
   logic [15:0] mchars_ff, mchars_in;
   logic [3:0]  month_ff,  month_in;
   logic [13:0] year_ff,   year_in;
   logic [6:0]  hour_ff,   hour_in;
   logic [6:0]  min_ff,    min_in;
   logic [6:0]  sec_ff,    sec_in;
   logic        err_ff,    err_in;
   logic        ok_ff,     ok_in;

   // conversion state
   logic [7:0]         q100n_ff, q100n_in;
   logic [7:0]         q100y_ff, q100y_in;
   logic [11:0]        leaps_ff, leaps_in;
   logic               leap_ff,  leap_in;
   logic [22:0]        ydays_ff, ydays_in;
   logic signed [23:0] days_ff,  days_in;
   logic [18:0]        hms_ff,   hms_in;
   logic               rsp_ok_ff,    rsp_ok_in;
   logic [38:0]        rsp_epoch_ff, rsp_epoch_in;

   logic               is_digit;
   logic [3:0]         dval;
   logic [7:0]         dsub;
   logic [13:0]        year_m1;
   logic [26:0]        prod_n;
   logic [26:0]        prod_y;
   logic [23:0]        leap_adj;
   logic signed [39:0] sec_wide;

   assign dsub     = char_byte - 8'h30;
   assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
   assign dval     = is_digit ? dsub[3:0] : 4'd0;
   assign year_m1  = year_ff - 14'd1;
   assign prod_n   = 27'(year_m1) * RECIP_100;
   assign prod_y   = 27'(year_ff) * RECIP_100;
   assign leap_adj = (leap_ff && (month_ff > MONTH_FEB)) ? 24'd1 : 24'd0;
   assign sec_wide = $signed(40'(days_ff)) * $signed(SECS_PER_DAY)
                   + $signed({21'b0, hms_ff});

   always_comb begin
      pos_in       = pos_ff;
      day_in       = day_ff;
      mchars_in    = mchars_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      hour_in      = hour_ff;
      min_in       = min_ff;
      sec_in       = sec_ff;
      err_in       = err_ff;
      ok_in        = ok_ff;
      q100n_in     = q100n_ff;
      q100y_in     = q100y_ff;
      leaps_in     = leaps_ff;
      leap_in      = leap_ff;
      ydays_in     = ydays_ff;
      days_in      = days_ff;
      hms_in       = hms_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_epoch_in = rsp_epoch_ff;

      if (cmd.parse_en) begin
         unique case (pos_ff) inside
            POS_DAY_TENS: begin
               day_in = 7'(dval) * 7'd10;
               err_in = err_ff | !is_digit;
            end
            POS_DAY_UNITS: begin
               day_in = day_ff + 7'(dval);
               err_in = err_ff | !is_digit;
            end
            POS_MON_FIRST: begin
               mchars_in = {char_byte, 8'h00};
            end
            POS_MON_SECOND: begin
               mchars_in = {mchars_ff[15:8], char_byte};
            end
            POS_MON_THIRD: begin
               month_in = month_lookup({mchars_ff, char_byte});
            end
            POS_YEAR_0, POS_YEAR_1, POS_YEAR_2, POS_YEAR_3: begin
               year_in = year_ff * 14'd10 + 14'(dval);
               err_in  = err_ff | !is_digit;
            end
            POS_HOUR_TENS: begin
               hour_in = 7'(dval) * 7'd10;
               err_in  = err_ff | !is_digit;
            end
            POS_HOUR_UNITS: begin
               hour_in = hour_ff + 7'(dval);
               err_in  = err_ff | !is_digit;
            end
            POS_MIN_TENS: begin
               min_in = 7'(dval) * 7'd10;
               err_in = err_ff | !is_digit;
            end
            POS_MIN_UNITS: begin
               min_in = min_ff + 7'(dval);
               err_in = err_ff | !is_digit;
            end
            POS_SEC_TENS: begin
               sec_in = 7'(dval) * 7'd10;
               err_in = err_ff | !is_digit;
            end
            POS_SEC_UNITS: begin
               sec_in = sec_ff + 7'(dval);
               err_in = err_ff | !is_digit;
            end
            default: begin
            end
         endcase
         if (pos_ff < DATE_LEN) begin
            pos_in = pos_ff + 5'd1;
         end
         // on the last beat every field is already final unless the string is short
         if (cmd.last_beat) begin
            ok_in = (pos_ff >= DATE_LEN - 5'd1) && (month_ff < MONTH_COUNT) && !err_ff;
         end
      end

      case (cmd.step)
         STEP_QUOT: begin
            q100n_in = prod_n[26:19];
         end
         STEP_LEAPS: begin
            q100y_in = prod_y[26:19];
            leaps_in = 12'(year_m1 >> 2) - 12'(q100n_ff) + 12'(q100n_ff >> 2);
         end
         STEP_YEAR: begin
            leap_in = (year_ff[1:0] == 2'd0)
                   && ((14'(q100y_ff) * 14'd100 != year_ff) || (q100y_ff[1:0] == 2'd0));
            if (year_ff > EPOCH_YEAR) begin
               ydays_in = 23'(year_ff - EPOCH_YEAR) * 23'd365 + 23'(leaps_ff) - LEAPS_TO_1969;
            end else begin
               ydays_in = 23'd0;
            end
         end
         STEP_DAYS: begin
            days_in = $signed(24'(ydays_ff) + 24'(days_before_month(month_ff)) + leap_adj
                    + 24'(day_ff) - 24'd1);
            hms_in  = 19'(hour_ff) * 19'd3600 + 19'(min_ff) * 19'd60 + 19'(sec_ff);
         end
         default: begin
         end
      endcase

      if ((cmd.step == STEP_SECS) || (cmd.step == STEP_FAIL)) begin
         rsp_ok_in    = (cmd.step == STEP_SECS);
         rsp_epoch_in = (cmd.step == STEP_SECS) ? sec_wide[38:0] : 39'd0;
         // fields are spent: back to the start-of-string state
         pos_in    = 5'd0;
         day_in    = 7'd0;
         mchars_in = 16'd0;
         month_in  = MONTH_NONE;
         year_in   = 14'd0;
         hour_in   = 7'd0;
         min_in    = 7'd0;
         sec_in    = 7'd0;
         err_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 5'd0;
         day_ff    <= 7'd0;
         mchars_ff <= 16'd0;
         month_ff  <= MONTH_NONE;
         year_ff   <= 14'd0;
         hour_ff   <= 7'd0;
         min_ff    <= 7'd0;
         sec_ff    <= 7'd0;
         err_ff    <= 1'b0;
         ok_ff     <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         day_ff    <= day_in;
         mchars_ff <= mchars_in;
         month_ff  <= month_in;
         year_ff   <= year_in;
         hour_ff   <= hour_in;
         min_ff    <= min_in;
         sec_ff    <= sec_in;
         err_ff    <= err_in;
         ok_ff     <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      q100n_ff     <= q100n_in;
      q100y_ff     <= q100y_in;
      leaps_ff     <= leaps_in;
      leap_ff      <= leap_in;
      ydays_ff     <= ydays_in;
      days_ff      <= days_in;
      hms_ff       <= hms_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_epoch_ff <= rsp_epoch_in;
   end

   assign sts.fields_ok     = ok_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_epoch_seconds = rsp_epoch_ff;

endmodule

`default_nettype wire

### rtl/core/http_date_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// HTTP date to epoch seconds - top level
// Converts a fixed-format HTTP date byte stream into seconds since 1970.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one date character per beat, tlast on the final character.
//            Bytes are taken one per cycle while no conversion is running.
//   rsp_*  : one beat per string: tuser = ok, tdata = signed epoch seconds
//            (zero when ok is low).
//   Sequence: after the last beat of a good date the five staged steps
//            (quotients, leap count, year days, days, seconds) run before
//            rsp_tvalid rises; a failed parse skips them.
//   Stall: the result is held in the output register while rsp_tready is
//            low; the first byte of the next string is taken in the cycle
//            the result beat completes, and nothing is taken before that.
//   Reset: synchronous, active high; clears the parser to the start of a
//            string and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "http_date_to_epoch_seconds_defines.svh"

module http_date_to_epoch_seconds
   import hdte_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_byte
   input  wire logic        req_tlast,   // last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [38:0] epoch_seconds, [39] zero
   output logic             rsp_tuser    // [0] ok
);

   hdte_cmd_type cmd;
   hdte_sts_type sts;
   logic [38:0]  epoch;

   hdte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hdte_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .char_byte         (req_tdata),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ok            (rsp_tuser),
      .rsp_epoch_seconds (epoch)
   );

   assign rsp_tdata = {1'b0, epoch};

   `HDTE_ASSERT_NOW(a_fail_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == 40'd0)
   `HDTE_ASSERT_NOW(a_take_drains, clock, reset, req_tready && rsp_tvalid, rsp_tready)
   `HDTE_ASSERT_NEXT(a_last_busy, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)
   `HDTE_ASSERT_NEXT(a_secs_out, clock, reset, cmd.step == STEP_SECS, rsp_tvalid && rsp_tuser)

endmodule

`default_nettype wire
